@@ src/sat_pkg.sv @@
// Shared types and constants of the section address translator.
`default_nettype none

package sat_pkg;

   // Operation codes of an input word.
   localparam logic [2:0] OP_LOAD        = 3'd0;
   localparam logic [2:0] OP_REL_TO_FILE = 3'd1;
   localparam logic [2:0] OP_ABS_TO_FILE = 3'd2;
   localparam logic [2:0] OP_FILE_TO_REL = 3'd3;
   localparam logic [2:0] OP_FILE_TO_ABS = 3'd4;
   localparam logic [2:0] OP_REL_TO_ABS  = 3'd5;

   // Configuration register indexes.
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 32;
   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_BASE    = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SECTION_COUNT = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_VALID   = 2'd2;

   // One section table entry, as held in the table memory.
   typedef struct packed {
      logic [31:0] virt_start;
      logic [31:0] virt_size;
      logic [31:0] raw_start;
      logic [31:0] raw_size;
   } entry_type;

   localparam int ENTRY_W = $bits(entry_type);

   // Configuration seen by the scan engine.
   typedef struct packed {
      logic [31:0] image_base;
      logic [7:0]  section_count;
      logic        image_valid;
   } cfg_type;

endpackage

`default_nettype wire

@@ src/sat_ram.sv @@
// Generic single-write, single-read synchronous RAM with a registered read.
`default_nettype none

module sat_ram #(
   parameter int WIDTH  = 32,
   parameter int DEPTH  = 128,
   parameter int ADDR_W = 7
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

@@ src/sat_scan.sv @@
// Sequencer and datapath that load table entries and scan them for lookups.
`default_nettype none

module sat_scan #(
   parameter int MAX_SECTIONS = 128,
   parameter int IDX_W        = 7
) (
   input  logic                clock,
   input  logic                reset,
   input  sat_pkg::cfg_type    cfg,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic [2:0]          req_op,
   input  logic [6:0]          req_load_index,
   input  logic [31:0]         req_entry_virt_start,
   input  logic [31:0]         req_entry_virt_size,
   input  logic [31:0]         req_entry_raw_start,
   input  logic [31:0]         req_entry_raw_size,
   input  logic [31:0]         req_addr,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [31:0]         rsp_translated,
   output logic                rsp_hit,
   output logic                ram_wr_en,
   output logic [IDX_W-1:0]    ram_wr_addr,
   output sat_pkg::entry_type  ram_wr_data,
   output logic                ram_rd_en,
   output logic [IDX_W-1:0]    ram_rd_addr,
   input  sat_pkg::entry_type  ram_rd_data
);

   import sat_pkg::*;

   localparam int CNT_W = $clog2(MAX_SECTIONS + 1);

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_SCAN = 3'd1;
   localparam logic [2:0] ST_ADD  = 3'd2;
   localparam logic [2:0] ST_BASE = 3'd3;
   localparam logic [2:0] ST_DONE = 3'd4;

   logic [2:0]       state_ff, state_in;
   logic [2:0]       op_ff, op_in;
   logic [31:0]      key_ff, key_in;
   logic [CNT_W-1:0] idx_ff, idx_in;
   logic             rd_vld_ff, rd_vld_in;
   logic [31:0]      diff_ff, diff_in;
   logic [31:0]      other_ff, other_in;
   logic [31:0]      res_ff, res_in;
   logic             hit_ff, hit_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [31:0]      rsp_translated_ff, rsp_translated_in;
   logic             rsp_hit_ff, rsp_hit_in;

   logic             accept;
   logic             is_lookup;
   logic             sub_base;
   logic [31:0]      base_sum;
   logic [CNT_W-1:0] limit;
   logic             virt_side;
   logic [31:0]      sel_start;
   logic [31:0]      sel_size;
   logic [31:0]      sel_other;
   logic [31:0]      sel_end;
   logic             match;
   logic             issue;
   logic             out_free;

   assign req_stall = (state_ff != ST_IDLE);
   assign accept    = req_valid && !req_stall;

   always_comb begin
      is_lookup = req_op inside {[OP_REL_TO_FILE:OP_REL_TO_ABS]};
   end

   // One adder serves both the image base subtraction and the addition.
   assign sub_base = (req_op == OP_ABS_TO_FILE);
   assign base_sum = req_addr + (sub_base ? ~cfg.image_base : cfg.image_base)
                     + {31'd0, sub_base};

   assign limit = (32'(cfg.section_count) > 32'(MAX_SECTIONS)) ?
                  CNT_W'(MAX_SECTIONS) : CNT_W'(cfg.section_count);

   // Loads are taken only while no lookup is running, so table writes never meet a scan.
   assign ram_wr_en   = accept && (req_op == OP_LOAD)
                        && (32'(req_load_index) < 32'(MAX_SECTIONS));
   assign ram_wr_addr = IDX_W'(req_load_index);
   assign ram_wr_data = '{virt_start: req_entry_virt_start,
                          virt_size:  req_entry_virt_size,
                          raw_start:  req_entry_raw_start,
                          raw_size:   req_entry_raw_size};

   assign virt_side = (op_ff == OP_REL_TO_FILE) || (op_ff == OP_ABS_TO_FILE);
   assign sel_start = virt_side ? ram_rd_data.virt_start : ram_rd_data.raw_start;
   assign sel_size  = virt_side ? ram_rd_data.virt_size  : ram_rd_data.raw_size;
   assign sel_other = virt_side ? ram_rd_data.raw_start  : ram_rd_data.virt_start;
   assign sel_end   = sel_start + sel_size;
   assign match     = rd_vld_ff && (key_ff >= sel_start) && (key_ff < sel_end);

   assign issue       = (state_ff == ST_SCAN) && !match && (idx_ff < limit);
   assign ram_rd_en   = issue;
   assign ram_rd_addr = idx_ff[IDX_W-1:0];

   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      state_in          = state_ff;
      op_in             = op_ff;
      key_in            = key_ff;
      idx_in            = idx_ff;
      rd_vld_in         = 1'b0;
      diff_in           = diff_ff;
      other_in          = other_ff;
      res_in            = res_ff;
      hit_in            = hit_ff;
      rsp_valid_in      = rsp_valid_ff && rsp_stall;
      rsp_translated_in = rsp_translated_ff;
      rsp_hit_in        = rsp_hit_ff;

      case (state_ff)
         ST_IDLE: begin
            if (accept && is_lookup) begin
               op_in  = req_op;
               key_in = sub_base ? base_sum : req_addr;
               idx_in = '0;
               if (!cfg.image_valid) begin
                  res_in   = '0;
                  hit_in   = 1'b0;
                  state_in = ST_DONE;
               end else if (req_op == OP_REL_TO_ABS) begin
                  res_in   = base_sum;
                  hit_in   = 1'b1;
                  state_in = ST_DONE;
               end else begin
                  state_in = ST_SCAN;
               end
            end
         end
         ST_SCAN: begin
            // The entry read last cycle is compared while the next one is read.
            rd_vld_in = issue;
            if (match) begin
               diff_in  = key_ff - sel_start;
               other_in = sel_other;
               state_in = ST_ADD;
            end else if (!issue) begin
               res_in   = (op_ff == OP_FILE_TO_ABS) ? cfg.image_base : '0;
               hit_in   = 1'b0;
               state_in = ST_DONE;
            end else begin
               idx_in = idx_ff + CNT_W'(1);
            end
         end
         ST_ADD: begin
            res_in   = diff_ff + other_ff;
            hit_in   = 1'b1;
            state_in = (op_ff == OP_FILE_TO_ABS) ? ST_BASE : ST_DONE;
         end
         ST_BASE: begin
            res_in   = res_ff + cfg.image_base;
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (out_free) begin
               rsp_valid_in      = 1'b1;
               rsp_translated_in = res_ff;
               rsp_hit_in        = hit_ff;
               state_in          = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         idx_ff       <= '0;
         rd_vld_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         idx_ff       <= idx_in;
         rd_vld_ff    <= rd_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff             <= op_in;
      key_ff            <= key_in;
      diff_ff           <= diff_in;
      other_ff          <= other_in;
      res_ff            <= res_in;
      hit_ff            <= hit_in;
      rsp_translated_ff <= rsp_translated_in;
      rsp_hit_ff        <= rsp_hit_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_translated = rsp_translated_ff;
   assign rsp_hit        = rsp_hit_ff;

endmodule

`default_nettype wire

@@ src/section_address_translator_top.sv @@
// Section address translator: configuration registers, section table memory and scan engine.
//
// The block holds a table of up to MAX_SECTIONS sections in one synchronous memory and
// translates addresses between relative-virtual, absolute-virtual and file-offset spaces.
// A load word or an unknown op gives no result and does not stall the input. A lookup gives one
// result word. With no valid image, or for relative-to-absolute, the engine goes straight
// to the done state. Otherwise the table is read one entry per cycle through the single
// read port. A lookup hitting an entry goes on to the add state and, for file-to-absolute,
// to the base state, which adds the image base, before the done state. A miss ends the
// scan after section_count entries, with section_count saturated at MAX_SECTIONS. The
// input is stalled from the acceptance of a lookup until its result moves from the done
// state into the output register, so the next word can be taken as soon as it is there.
// The move happens only once the output register is free. A new item is therefore taken
// while the previous result still waits there. The table needs no clearing after reset;
// entries must be loaded before a lookup scans them.
`default_nettype none

module section_address_translator_top #(
   parameter int MAX_SECTIONS = 128
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic [2:0]                      req_op,
   input  logic [6:0]                      req_load_index,
   input  logic [31:0]                     req_entry_virt_start,
   input  logic [31:0]                     req_entry_virt_size,
   input  logic [31:0]                     req_entry_raw_start,
   input  logic [31:0]                     req_entry_raw_size,
   input  logic [31:0]                     req_addr,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic [31:0]                     rsp_translated,
   output logic                            rsp_hit,
   input  logic                            csr_wr_en,
   input  logic [sat_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [sat_pkg::CSR_DATA_W-1:0]  csr_wdata
);

   import sat_pkg::*;

   localparam int IDX_W = (MAX_SECTIONS > 1) ? $clog2(MAX_SECTIONS) : 1;

   logic [31:0] image_base_ff, image_base_in;
   logic [7:0]  section_count_ff, section_count_in;
   logic        image_valid_ff, image_valid_in;
   cfg_type     cfg;

   logic               ram_wr_en;
   logic [IDX_W-1:0]   ram_wr_addr;
   entry_type          ram_wr_data;
   logic               ram_rd_en;
   logic [IDX_W-1:0]   ram_rd_addr;
   logic [ENTRY_W-1:0] ram_rd_bits;

   always_comb begin
      image_base_in    = image_base_ff;
      section_count_in = section_count_ff;
      image_valid_in   = image_valid_ff;
      if (csr_wr_en) begin
         case (csr_index)
            CSR_IMAGE_BASE:    image_base_in    = csr_wdata;
            CSR_SECTION_COUNT: section_count_in = csr_wdata[7:0];
            CSR_IMAGE_VALID:   image_valid_in   = csr_wdata[0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         image_base_ff    <= '0;
         section_count_ff <= '0;
         image_valid_ff   <= 1'b0;
      end else begin
         image_base_ff    <= image_base_in;
         section_count_ff <= section_count_in;
         image_valid_ff   <= image_valid_in;
      end
   end

   assign cfg = '{image_base:    image_base_ff,
                  section_count: section_count_ff,
                  image_valid:   image_valid_ff};

   sat_ram #(
      .WIDTH  (ENTRY_W),
      .DEPTH  (MAX_SECTIONS),
      .ADDR_W (IDX_W)
   ) u_table (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_bits)
   );

   sat_scan #(
      .MAX_SECTIONS (MAX_SECTIONS),
      .IDX_W        (IDX_W)
   ) u_scan (
      .clock                (clock),
      .reset                (reset),
      .cfg                  (cfg),
      .req_valid            (req_valid),
      .req_stall            (req_stall),
      .req_op               (req_op),
      .req_load_index       (req_load_index),
      .req_entry_virt_start (req_entry_virt_start),
      .req_entry_virt_size  (req_entry_virt_size),
      .req_entry_raw_start  (req_entry_raw_start),
      .req_entry_raw_size   (req_entry_raw_size),
      .req_addr             (req_addr),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_translated       (rsp_translated),
      .rsp_hit              (rsp_hit),
      .ram_wr_en            (ram_wr_en),
      .ram_wr_addr          (ram_wr_addr),
      .ram_wr_data          (ram_wr_data),
      .ram_rd_en            (ram_rd_en),
      .ram_rd_addr          (ram_rd_addr),
      .ram_rd_data          (entry_type'(ram_rd_bits))
   );

endmodule

`default_nettype wire

@@ src/sat_checker.sv @@
// Port-level checks of the section address translator, bound to its top level.
`default_nettype none

module sat_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_valid,
   input logic                            req_stall,
   input logic [2:0]                      req_op,
   input logic                            rsp_valid,
   input logic                            rsp_stall,
   input logic [31:0]                     rsp_translated,
   input logic                            rsp_hit
);

   import sat_pkg::*;

   logic req_take;
   logic lookup_op;

   assign req_take  = req_valid && !req_stall;
   assign lookup_op = (req_op == OP_REL_TO_FILE) || (req_op == OP_ABS_TO_FILE) ||
                      (req_op == OP_FILE_TO_REL) || (req_op == OP_FILE_TO_ABS) ||
                      (req_op == OP_REL_TO_ABS);

   // No result word may appear straight out of reset.
   a_reset_quiet: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result word valid after reset");

   // A result word held by the consumer must keep its contents.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_translated) && $stable(rsp_hit)))
      else $error("stalled result word changed");

   // A lookup occupies the engine, so the next word must wait.
   a_lookup_busy: assert property (@(posedge clock) disable iff (reset)
      (req_take && lookup_op) |=> req_stall)
      else $error("word taken while a lookup was starting");

   // A load finishes at once and never produces a result word.
   a_load_silent: assert property (@(posedge clock) disable iff (reset)
      (req_take && (req_op == OP_LOAD) && !rsp_valid) |=> (!req_stall && !rsp_valid))
      else $error("load word produced a result or blocked the input");

endmodule

bind section_address_translator_top sat_checker u_sat_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_valid),
   .req_stall      (req_stall),
   .req_op         (req_op),
   .rsp_valid      (rsp_valid),
   .rsp_stall      (rsp_stall),
   .rsp_translated (rsp_translated),
   .rsp_hit        (rsp_hit)
);

`default_nettype wire
